[hdl/sha1he_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared widths, round constants, round functions and the control bundles
// that pass between the sequencer, the hash store and the round core.
// ----------------------------------------------------------------------------
package sha1he_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned HashWords = 5;
  localparam int unsigned HashAw    = 3;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned BlkAw     = 4;
  localparam int unsigned RoundW    = 7;
  localparam int unsigned PosW      = 6;
  localparam int unsigned CountW    = 64;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  // Control of the round core for one cycle.
  typedef struct packed {
    logic              load;   // shift a hash word in at e
    logic              step;   // run one compression round
    logic              drain;  // shift the working variables towards a
    logic [RoundW-1:0] t;      // round number
  } rc_ctrl_t;

  // Access to the hash word store for one cycle.
  typedef struct packed {
    logic              rd_en;
    logic [HashAw-1:0] rd_addr;
    logic              wr_en;
    logic [HashAw-1:0] wr_addr;
    logic [WordW-1:0]  wr_data;
    logic              clr_en;
    logic [HashAw-1:0] clr_addr;
  } hash_req_t;

  function automatic logic [WordW-1:0] init_hash(input logic [HashAw-1:0] idx);
    logic [WordW-1:0] v;
    unique case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      3'd4:    v = 32'hC3D2E1F0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] v);
    return {v[WordW-2:0], v[WordW-1]};
  endfunction

  function automatic logic [WordW-1:0] rotl5(input logic [WordW-1:0] v);
    return {v[WordW-6:0], v[WordW-1:WordW-5]};
  endfunction

  function automatic logic [WordW-1:0] rotl30(input logic [WordW-1:0] v);
    return {v[1:0], v[WordW-1:2]};
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] t);
    logic [WordW-1:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RoundW-1:0] t,
                                               input logic [WordW-1:0]  b,
                                               input logic [WordW-1:0]  c,
                                               input logic [WordW-1:0]  d);
    logic [WordW-1:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t >= 7'd40 && t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

[hdl/sha1he_blk_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 block store
// Sixteen-word message block memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module sha1he_blk_mem (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [sha1he_pkg::BlkAw-1:0]          waddr_i,
  input  wire logic [sha1he_pkg::WordW-1:0]          wdata_i,
  input  wire logic [sha1he_pkg::BlkAw-1:0]          raddr_i,
  output      logic [sha1he_pkg::WordW-1:0]          rdata_o
);
  import sha1he_pkg::*;

  logic [WordW-1:0] mem_q [BlkWords];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/sha1he_hash_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 hash word store
// Five-word memory with a valid bit per entry; an entry that is not valid
// reads as its initial hash value, so reset and digest emission need no fill.
// ----------------------------------------------------------------------------
module sha1he_hash_mem (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sha1he_pkg::hash_req_t        req_i,
  output      logic [sha1he_pkg::WordW-1:0] rdata_o
);
  import sha1he_pkg::*;

  logic [WordW-1:0]     mem_q [HashWords];
  logic [HashWords-1:0] valid_q;
  logic [WordW-1:0]     rd_data_q;
  logic                 rd_valid_q;
  logic [HashAw-1:0]    rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q  <= mem_q[req_i.rd_addr];
      rd_valid_q <= valid_q[req_i.rd_addr];
      rd_addr_q  <= req_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.clr_en) begin
        valid_q[req_i.clr_addr] <= 1'b0;
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_data_q : init_hash(rd_addr_q);

endmodule
`default_nettype wire

[hdl/sha1he_round_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 round core
// Working variables a to e and the sixteen-word message schedule window.
// One compression round per cycle.
// ----------------------------------------------------------------------------
module sha1he_round_core (
  input  wire logic                         clk_i,
  input  wire sha1he_pkg::rc_ctrl_t         ctrl_i,
  input  wire logic [sha1he_pkg::WordW-1:0] hash_i,
  input  wire logic [sha1he_pkg::WordW-1:0] blk_i,
  output      logic [sha1he_pkg::WordW-1:0] a_o
);
  import sha1he_pkg::*;

  logic [WordW-1:0] v_q [HashWords];
  logic [WordW-1:0] w_q [BlkWords];
  logic [WordW-1:0] wt;
  logic [WordW-1:0] nxt;

  // The window holds W[t-16] at the bottom and W[t-1] at the top.
  assign wt  = (ctrl_i.t < 7'd16) ? blk_i : rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
  assign nxt = rotl5(v_q[0]) + round_f(ctrl_i.t, v_q[1], v_q[2], v_q[3])
             + v_q[4] + wt + round_k(ctrl_i.t);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < HashWords - 1; i++) begin
        v_q[i] <= v_q[i+1];
      end
      v_q[HashWords-1] <= hash_i;
    end else if (ctrl_i.step) begin
      v_q[4] <= v_q[3];
      v_q[3] <= v_q[2];
      v_q[2] <= rotl30(v_q[1]);
      v_q[1] <= v_q[0];
      v_q[0] <= nxt;
      for (int i = 0; i < BlkWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlkWords-1] <= wt;
    end else if (ctrl_i.drain) begin
      for (int i = 0; i < HashWords - 1; i++) begin
        v_q[i] <= v_q[i+1];
      end
    end
  end

  assign a_o = v_q[0];

endmodule
`default_nettype wire

[hdl/sha1_hash_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Hashes a byte stream and returns the 160-bit digest as five words.
// ----------------------------------------------------------------------------
// Input channel: one transfer per item, carrying an optional message byte
// and an end-of-message mark. The 64th byte of a block adds a compression
// (loading the hash words, 80 rounds in the single round core, then
// write-back through the hash store port); no item is taken meanwhile.
// The item with the end mark pads the block byte by byte (one byte a cycle
// while no compression runs, at most 72 pad bytes and up to two
// compressions), then returns the digest on the output channel as five
// transfers, word 0 first, each word read from the hash store, registered
// and held until taken. No new input item is taken until the fifth word
// has gone. A stall on the output holds the current word and the engine
// waits. After reset the hash words read as the initial values, the bit
// count and fill position are zero and the engine is ready for a new
// message; the same holds after every digest.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [7:0]                   data_byte_i,
  input  wire logic                         byte_present_i,
  input  wire logic                         is_last_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [sha1he_pkg::WordW-1:0] digest_word_o,
  output      logic [2:0]                   word_index_o,
  output      logic                         last_word_o
);
  import sha1he_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LDH   = 4'd1;
  localparam logic [3:0] S_RND   = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_PMARK = 4'd4;
  localparam logic [3:0] S_PZERO = 4'd5;
  localparam logic [3:0] S_PLEN  = 4'd6;
  localparam logic [3:0] S_ERD   = 4'd7;
  localparam logic [3:0] S_ELD   = 4'd8;
  localparam logic [3:0] S_EWT   = 4'd9;

  localparam logic [RoundW-1:0] LastRound = 7'd79;
  localparam logic [RoundW-1:0] LastHash  = 7'd4;
  localparam logic [RoundW-1:0] HashEnd   = 7'd5;
  localparam logic [PosW-1:0]   LenPos    = 6'd56;
  localparam logic [PosW-1:0]   LastPos   = 6'd63;
  localparam logic [7:0]        PadMark   = 8'h80;

  logic [3:0]        state_q, state_d, ret_q, ret_d, nominal;
  logic [RoundW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] bit_count_q, bit_count_d;
  logic [2:0]        len_q, len_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_word_q, out_word_d;
  logic [2:0]        out_idx_q, out_idx_d;

  logic              put_en;
  logic [7:0]        put_byte;
  logic [WordW-1:0]  word_new;
  logic [BlkAw-1:0]  blk_raddr;
  logic [WordW-1:0]  blk_rdata;
  logic [WordW-1:0]  hash_rdata;
  logic [WordW-1:0]  a_var;
  hash_req_t         hreq;
  rc_ctrl_t          rc;

  // Big-endian packing of the byte into the word being filled.
  always_comb begin
    unique case (pos_q[1:0])
      2'd0: word_new = {put_byte, 24'h000000};
      2'd1: word_new = acc_q | {8'h00, put_byte, 16'h0000};
      2'd2: word_new = acc_q | {16'h0000, put_byte, 8'h00};
      2'd3: word_new = acc_q | {24'h000000, put_byte};
      default: word_new = '0;
    endcase
  end

  always_comb begin
    nominal     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    bit_count_d = bit_count_q;
    len_d       = len_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    put_en      = 1'b0;
    put_byte    = 8'h00;
    blk_raddr   = '0;
    hreq        = '0;
    rc          = '0;
    rc.t        = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            put_en      = 1'b1;
            put_byte    = data_byte_i;
            bit_count_d = bit_count_q + 64'd8;
          end
          nominal = is_last_i ? S_PMARK : S_IDLE;
        end
      end
      S_PMARK: begin
        put_en   = 1'b1;
        put_byte = PadMark;
        nominal  = S_PZERO;
      end
      S_PZERO: begin
        if (pos_q == LenPos) begin
          nominal = S_PLEN;
        end else begin
          put_en = 1'b1;
        end
      end
      S_PLEN: begin
        // The bit count shifts out its top byte, so it is zero afterwards.
        put_en      = 1'b1;
        put_byte    = bit_count_q[63:56];
        bit_count_d = {bit_count_q[55:0], 8'h00};
        len_d       = len_q + 3'd1;
        nominal     = (len_q == 3'd7) ? S_ERD : S_PLEN;
      end
      S_LDH: begin
        hreq.rd_en   = (cnt_q < HashEnd);
        hreq.rd_addr = cnt_q[2:0];
        rc.load      = (cnt_q != '0);
        if (cnt_q == HashEnd) begin
          nominal = S_RND;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_RND: begin
        rc.step   = 1'b1;
        blk_raddr = cnt_q[3:0] + 4'd1;
        if (cnt_q == LastRound) begin
          nominal = S_UPD;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_UPD: begin
        // Read word k while word k-1 is written back with its sum.
        hreq.rd_en   = (cnt_q < HashEnd);
        hreq.rd_addr = cnt_q[2:0];
        hreq.wr_en   = (cnt_q != '0);
        hreq.wr_addr = cnt_q[2:0] - 3'd1;
        hreq.wr_data = hash_rdata + a_var;
        rc.drain     = (cnt_q != '0);
        if (cnt_q == HashEnd) begin
          nominal = ret_q;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_ERD: begin
        hreq.rd_en   = 1'b1;
        hreq.rd_addr = cnt_q[2:0];
        nominal      = S_ELD;
      end
      S_ELD: begin
        out_word_d    = hash_rdata;
        out_idx_d     = cnt_q[2:0];
        out_valid_d   = 1'b1;
        hreq.clr_en   = 1'b1;
        hreq.clr_addr = cnt_q[2:0];
        nominal       = S_EWT;
      end
      S_EWT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (cnt_q == LastHash) begin
            nominal = S_IDLE;
            cnt_d   = '0;
          end else begin
            nominal = S_ERD;
            cnt_d   = cnt_q + 7'd1;
          end
        end
      end
      default: begin
        nominal = S_IDLE;
      end
    endcase

    state_d = nominal;
    if (put_en) begin
      pos_d = pos_q + 6'd1;
      acc_d = word_new;
      // A full block goes to compression and comes back to the next step.
      if (pos_q == LastPos) begin
        state_d = S_LDH;
        ret_d   = nominal;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      bit_count_q <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      bit_count_q <= bit_count_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
  end

  sha1he_blk_mem u_blk_mem (
    .clk_i   (clk_i),
    .we_i    (put_en),
    .waddr_i (pos_q[5:2]),
    .wdata_i (word_new),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  sha1he_hash_mem u_hash_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (hreq),
    .rdata_o (hash_rdata)
  );

  sha1he_round_core u_round_core (
    .clk_i  (clk_i),
    .ctrl_i (rc),
    .hash_i (hash_rdata),
    .blk_i  (blk_rdata),
    .a_o    (a_var)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 3'd4);

  // A digest word is only presented while the emitter waits for its transfer.
  a_out_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_EWT))
    else $error("digest word presented outside the output wait state");

  // Compression always starts on a complete block.
  a_cmp_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LDH && cnt_q == '0) |-> (pos_q == '0))
    else $error("compression started on a partly filled block");

  // The eighth length byte completes the final block.
  a_len_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLEN && len_q == 3'd7) |=> (state_q == S_LDH && ret_q == S_ERD))
    else $error("final length byte did not start the last compression");

  // By the time the digest is read out, the length has been fully shifted out.
  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERD) |-> (bit_count_q == '0 && pos_q == '0))
    else $error("bit count or fill position not cleared before digest output");

  // Word indices stay within the digest.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (word_index_o <= 3'd4))
    else $error("digest word index out of range");

endmodule
`default_nettype wire
